/* rtl/gbs_pkg.sv */
// ---------------------------------------------------------------------------
// gbs_pkg: shared types and constants
// Box record, cell control group, pair-unit latency, configuration indexes.
// ---------------------------------------------------------------------------
`default_nettype none
package gbs_pkg;

  localparam int unsigned CoordW = 20;
  localparam int unsigned ScoreW = 24;
  localparam int unsigned PctW   = 7;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_SUPPRESS_ENABLE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_UNION_DENOMINATOR = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OVERLAP_PERCENT   = 2'd2;

  localparam logic [PctW-1:0] PCT_RESET = 7'd65;

  // Pair unit: cycles from issue until the drop decision is applied
  localparam int unsigned PairLatency = 5;

  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
    logic [ScoreW-1:0] score;
  } box_t;

  typedef struct packed {
    logic rotate;
    logic insert;
    logic sort;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/greedy_box_suppression.sv */
// ---------------------------------------------------------------------------
// greedy_box_suppression: greedy non-maximum suppression of one frame
// Ring of box cells sorted on load when suppression is enabled, shared overlap pipeline, ordered output.
// ---------------------------------------------------------------------------
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   left..score, frame_end
// out       output     out_valid_o / out_stall_i out_left..out_score, out_last
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// Boxes load one per cycle into the ring, sorted when suppression is enabled;
// no item is taken while a frame is processed. Suppression works by the ring
// turning once past the shared overlap pipeline per kept outer box; the output
// pass then visits every stored box in order, one per cycle when out_stall_i
// stays low, and emits the kept ones. Reset empties the frame and restores the
// registers; stall on the output holds the result register and, in the output
// pass, the ring.
// ---------------------------------------------------------------------------
`default_nettype none
module greedy_box_suppression #(
  parameter int unsigned MAX_BOXES = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [19:0] left_i,
  input  wire  [19:0] top_i,
  input  wire  [19:0] right_i,
  input  wire  [19:0] bottom_i,
  input  wire  signed [23:0] score_i,
  input  wire         frame_end_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [19:0] out_left_o,
  output logic [19:0] out_top_o,
  output logic [19:0] out_right_o,
  output logic [19:0] out_bottom_o,
  output logic signed [23:0] out_score_o,
  output logic        out_last_o,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_idx_i,
  input  wire  [6:0]  cfg_wdata_i
);

  localparam int unsigned IW = $clog2(MAX_BOXES);
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam int unsigned DW = $clog2(gbs_pkg::PairLatency + 1);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_ROW   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_SEEK  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] head_q, head_d, row_q, row_d;
  logic [DW-1:0] drain_q, drain_d;
  logic [MAX_BOXES-1:0] keep_q, keep_d;
  logic sup_en_q, union_q;
  logic [gbs_pkg::PctW-1:0] pct_q;

  gbs_pkg::box_t a_q, a_d;
  gbs_pkg::box_t x_box;
  gbs_pkg::box_t cell_box [MAX_BOXES];
  gbs_pkg::box_t cell_next [MAX_BOXES];
  gbs_pkg::box_t cell_prev [MAX_BOXES];
  logic [MAX_BOXES-1:0] cell_lt, cell_lt_prev, cell_occ, cell_end, above;
  gbs_pkg::cell_ctrl_t ctrl;

  logic in_acc, rotate, issue, drop, out_free, emit_load, last_kept;
  logic [IW-1:0] drop_idx;
  logic [CW-1:0] head_ext, row_ext, cnt_new;
  logic o_valid_q, o_valid_d, o_last_q;
  gbs_pkg::box_t o_box_q;

  assign x_box = '{left: left_i, top: top_i, right: right_i, bottom: bottom_i,
                   score: score_i};
  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign head_ext   = CW'(head_q);
  assign row_ext    = CW'(row_q);
  assign cnt_new    = (cnt_q < CW'(MAX_BOXES)) ? cnt_q + 1'b1 : cnt_q;
  assign out_free   = !o_valid_q || !out_stall_i;

  // ring of cells
  genvar k;
  generate
    for (k = 0; k < MAX_BOXES; k++) begin : g_cell
      localparam logic [CW-1:0] K = CW'(k);
      if (k == MAX_BOXES - 1) begin : g_wrap
        assign cell_next[k] = cell_box[0];
      end else begin : g_link
        assign cell_next[k] = (K + 1'b1 == cnt_q) ? cell_box[0] : cell_box[k+1];
      end
      if (k == 0) begin : g_first
        assign cell_prev[k]    = x_box;
        assign cell_lt_prev[k] = 1'b0;
      end else begin : g_rest
        assign cell_prev[k]    = cell_box[k-1];
        assign cell_lt_prev[k] = cell_lt[k-1];
      end
      assign cell_occ[k] = (K < cnt_q);
      assign cell_end[k] = (K == cnt_q);
      assign above[k]    = keep_q[k] && (K < cnt_q) && (K > head_ext);

      gbs_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .occupied_i (cell_occ[k]),
        .at_end_i   (cell_end[k]),
        .x_i        (x_box),
        .prev_i     (cell_prev[k]),
        .next_i     (cell_next[k]),
        .lt_prev_i  (cell_lt_prev[k]),
        .lt_o       (cell_lt[k]),
        .box_o      (cell_box[k])
      );
    end
  endgenerate

  assign last_kept = ~|above;

  gbs_pair #(.IdxW(IW)) u_pair (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .issue_i    (issue),
    .idx_i      (head_q),
    .a_i        (a_q),
    .b_i        (cell_box[0]),
    .union_i    (union_q),
    .pct_i      (pct_q),
    .drop_o     (drop),
    .drop_idx_o (drop_idx)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    row_d     = row_q;
    drain_d   = drain_q;
    keep_d    = keep_q;
    a_d       = a_q;
    rotate    = 1'b0;
    issue     = 1'b0;
    emit_load = 1'b0;

    if (drop) begin
      keep_d[drop_idx] = 1'b0;
    end

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          cnt_d = cnt_new;
          if (frame_end_i) begin
            if (sup_en_q && (cnt_new > CW'(1))) begin
              state_d = S_START;
              row_d   = '0;
            end else begin
              state_d = S_EMIT;
            end
          end
        end
      end
      S_START: begin
        if (head_q == row_q) begin
          a_d    = cell_box[0];
          rotate = 1'b1;
          if (keep_q[row_q]) begin
            state_d = S_ROW;
          end else if (row_ext + CW'(2) == cnt_q) begin
            state_d = S_SEEK;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          rotate = 1'b1;
        end
      end
      S_ROW: begin
        issue  = keep_q[head_q];
        rotate = 1'b1;
        if (head_ext + 1'b1 == cnt_q) begin
          state_d = S_DRAIN;
          drain_d = DW'(gbs_pkg::PairLatency);
        end
      end
      S_DRAIN: begin
        rotate = 1'b1;
        if (drain_q == '0) begin
          if (row_ext + CW'(2) == cnt_q) begin
            state_d = S_SEEK;
          end else begin
            state_d = S_START;
            row_d   = row_q + 1'b1;
          end
        end else begin
          drain_d = drain_q - 1'b1;
        end
      end
      S_SEEK: begin
        if (head_q == '0) begin
          state_d = S_EMIT;
        end else begin
          rotate = 1'b1;
        end
      end
      S_EMIT: begin
        if (!keep_q[head_q] || out_free) begin
          emit_load = keep_q[head_q];
          if (head_ext + 1'b1 == cnt_q) begin
            state_d = S_LOAD;
            cnt_d   = '0;
            keep_d  = '1;
          end else begin
            rotate = 1'b1;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_comb begin
    if (state_q == S_LOAD) begin
      head_d = '0;
    end else if (rotate) begin
      head_d = (head_ext + 1'b1 == cnt_q) ? '0 : head_q + 1'b1;
    end else begin
      head_d = head_q;
    end
  end

  assign ctrl = '{rotate: rotate,
                  insert: in_acc && (cnt_q < CW'(MAX_BOXES)),
                  sort:   sup_en_q};

  always_comb begin
    o_valid_d = o_valid_q;
    if (emit_load) begin
      o_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      cnt_q     <= '0;
      head_q    <= '0;
      row_q     <= '0;
      drain_q   <= '0;
      keep_q    <= '1;
      o_valid_q <= 1'b0;
      sup_en_q  <= 1'b1;
      union_q   <= 1'b0;
      pct_q     <= gbs_pkg::PCT_RESET;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      head_q    <= head_d;
      row_q     <= row_d;
      drain_q   <= drain_d;
      keep_q    <= keep_d;
      o_valid_q <= o_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          gbs_pkg::CFG_SUPPRESS_ENABLE:   sup_en_q <= cfg_wdata_i[0];
          gbs_pkg::CFG_UNION_DENOMINATOR: union_q  <= cfg_wdata_i[0];
          gbs_pkg::CFG_OVERLAP_PERCENT:   pct_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    if (emit_load) begin
      o_box_q  <= cell_box[0];
      o_last_q <= last_kept;
    end
  end

  assign out_valid_o  = o_valid_q;
  assign out_left_o   = o_box_q.left;
  assign out_top_o    = o_box_q.top;
  assign out_right_o  = o_box_q.right;
  assign out_bottom_o = o_box_q.bottom;
  assign out_score_o  = o_box_q.score;
  assign out_last_o   = o_last_q;

endmodule
`default_nettype wire

/* rtl/gbs_cell.sv */
// ---------------------------------------------------------------------------
// gbs_cell: one box slot of the sorting ring
// Inserts in score order (at the tail when sorting is off), shifts towards the tail, or rotates the ring.
// ---------------------------------------------------------------------------
`default_nettype none
module gbs_cell (
  input  wire                       clk_i,
  input  wire gbs_pkg::cell_ctrl_t  ctrl_i,
  input  wire                       occupied_i,
  input  wire                       at_end_i,
  input  wire gbs_pkg::box_t        x_i,
  input  wire gbs_pkg::box_t        prev_i,
  input  wire gbs_pkg::box_t        next_i,
  input  wire                       lt_prev_i,
  output logic                      lt_o,
  output gbs_pkg::box_t             box_o
);

  gbs_pkg::box_t box_q, box_d;

  // strictly lower score: equal scores stay ahead of the newcomer
  assign lt_o = ctrl_i.sort && occupied_i && ($signed(box_q.score) < $signed(x_i.score));

  always_comb begin
    box_d = box_q;
    if (ctrl_i.rotate) begin
      box_d = next_i;
    end else if (ctrl_i.insert) begin
      if (lt_prev_i) begin
        box_d = prev_i;
      end else if (lt_o || at_end_i) begin
        box_d = x_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    box_q <= box_d;
  end

  assign box_o = box_q;

endmodule
`default_nettype wire

/* rtl/gbs_pair.sv */
// ---------------------------------------------------------------------------
// gbs_pair: pipelined overlap test of two boxes
// Four register stages: extents, products, denominator, threshold product.
// ---------------------------------------------------------------------------
`default_nettype none
module gbs_pair #(
  parameter int unsigned IdxW = 6
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        issue_i,
  input  wire [IdxW-1:0]             idx_i,
  input  wire gbs_pkg::box_t         a_i,
  input  wire gbs_pkg::box_t         b_i,
  input  wire                        union_i,
  input  wire [gbs_pkg::PctW-1:0]    pct_i,
  output logic                       drop_o,
  output logic [IdxW-1:0]            drop_idx_o
);

  logic [gbs_pkg::CoordW-1:0] min_r, max_l, min_b, max_t;
  logic signed [20:0] iw, ih;

  // stage 1
  logic               v1_q, hit1_q;
  logic [IdxW-1:0]    idx1_q;
  logic [19:0]        iw1_q, ih1_q;
  logic signed [20:0] wa1_q, ha1_q, wb1_q, hb1_q;
  // stage 2
  logic               v2_q;
  logic [IdxW-1:0]    idx2_q;
  logic [39:0]        inter2_q;
  logic signed [41:0] aa2_q, ab2_q;
  // stage 3
  logic               v3_q;
  logic [IdxW-1:0]    idx3_q;
  logic [46:0]        lhs3_q;
  logic signed [43:0] den3_q;
  // stage 4
  logic               v4_q;
  logic [IdxW-1:0]    idx4_q;
  logic [46:0]        lhs4_q;
  logic signed [51:0] rhs4_q;

  logic signed [43:0] den_d;

  always_comb begin
    min_r = (a_i.right  < b_i.right)  ? a_i.right  : b_i.right;
    max_l = (a_i.left   > b_i.left)   ? a_i.left   : b_i.left;
    min_b = (a_i.bottom < b_i.bottom) ? a_i.bottom : b_i.bottom;
    max_t = (a_i.top    > b_i.top)    ? a_i.top    : b_i.top;
    iw = $signed({1'b0, min_r}) - $signed({1'b0, max_l});
    ih = $signed({1'b0, min_b}) - $signed({1'b0, max_t});
  end

  always_comb begin
    if (union_i) begin
      den_d = 44'(aa2_q) + 44'(ab2_q) - $signed({4'b0, inter2_q});
    end else begin
      den_d = (aa2_q < ab2_q) ? 44'(aa2_q) : 44'(ab2_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      // drop a pair that does not overlap in both axes at once
      v1_q <= issue_i;
      v2_q <= v1_q && hit1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit1_q   <= !iw[20] && (iw != '0) && !ih[20] && (ih != '0);
    idx1_q   <= idx_i;
    iw1_q    <= iw[19:0];
    ih1_q    <= ih[19:0];
    wa1_q    <= $signed({1'b0, a_i.right})  - $signed({1'b0, a_i.left});
    ha1_q    <= $signed({1'b0, a_i.bottom}) - $signed({1'b0, a_i.top});
    wb1_q    <= $signed({1'b0, b_i.right})  - $signed({1'b0, b_i.left});
    hb1_q    <= $signed({1'b0, b_i.bottom}) - $signed({1'b0, b_i.top});

    idx2_q   <= idx1_q;
    inter2_q <= iw1_q * ih1_q;
    aa2_q    <= wa1_q * ha1_q;
    ab2_q    <= wb1_q * hb1_q;

    idx3_q   <= idx2_q;
    lhs3_q   <= 47'(inter2_q) * 47'd100;
    den3_q   <= den_d;

    idx4_q   <= idx3_q;
    lhs4_q   <= lhs3_q;
    rhs4_q   <= 52'($signed({1'b0, pct_i})) * 52'(den3_q);
  end

  assign drop_o     = v4_q && ($signed({5'b0, lhs4_q}) > rhs4_q);
  assign drop_idx_o = idx4_q;

endmodule
`default_nettype wire

/* rtl/gbs_checker.sv */
// ---------------------------------------------------------------------------
// gbs_checker: port-level properties of the suppression block
// Watches both channels and is bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module gbs_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        frame_end_i,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [19:0] out_left_o,
  input wire [23:0] out_score_o,
  input wire        out_last_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_left_o)
      && $stable(out_score_o) && $stable(out_last_o))
    else $error("stalled result changed");

  // the closing transaction of a frame makes the input busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && frame_end_i |=> in_stall_o)
    else $error("input not held after frame end");

  // a fresh result is only loaded while the input is held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || !out_stall_i |=> !out_valid_o || $past(in_stall_o))
    else $error("result loaded while input open");

  // while a frame loads, a result may leave but never appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && !$past(in_stall_o) |-> !out_valid_o || $past(out_valid_o))
    else $error("result during load");

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .frame_end_i (frame_end_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_left_o  (out_left_o),
  .out_score_o (out_score_o),
  .out_last_o  (out_last_o)
);
`default_nettype wire

/* tb/tb_greedy_box_suppression.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_greedy_box_suppression: self-checking bench for box suppression
// Frames of random and directed boxes are sent in, mostly with random gaps; a local
// model sorts and suppresses each frame when enabled, and a scoreboard checks every output.
// ---------------------------------------------------------------------------
module tb_greedy_box_suppression;

  localparam int unsigned NBoxes = 64;

  typedef struct {
    logic [19:0] l, t, r, b;
    logic [23:0] s;
    logic        last;
  } det_t;

  class suppression_board;
    bit         en_sup = 1'b1;
    bit         use_union = 1'b0;
    int         pct = 65;
    det_t       frame_boxes[$];
    det_t       kept_q[$];
    int         mismatches;
    int         results_seen;

    function longint area(det_t d);
      return (longint'(d.r) - longint'(d.l)) * (longint'(d.b) - longint'(d.t));
    endfunction

    function void note_box(det_t d);
      det_t   ord[$];
      bit     keep[$];
      int     j, last_pos;
      longint iw, ih, inter, aa, ab, den;
      det_t   cur, o;
      if (frame_boxes.size() < NBoxes) frame_boxes = {frame_boxes, d};
      if (!d.last) return;
      ord = frame_boxes;
      if (en_sup) begin
        for (int i = 1; i < ord.size(); i++) begin
          cur = ord[i];
          j = i - 1;
          while (j >= 0 && $signed(ord[j].s) < $signed(cur.s)) begin
            ord[j + 1] = ord[j];
            j--;
          end
          ord[j + 1] = cur;
        end
      end
      foreach (ord[i]) keep = {keep, 1'b1};
      if (en_sup) begin
        for (int i = 0; i < ord.size(); i++) begin
          if (!keep[i]) continue;
          for (int k = i + 1; k < ord.size(); k++) begin
            if (!keep[k]) continue;
            iw = (ord[i].r < ord[k].r ? longint'(ord[i].r) : longint'(ord[k].r)) -
                 (ord[i].l > ord[k].l ? longint'(ord[i].l) : longint'(ord[k].l));
            if (iw <= 0) continue;
            ih = (ord[i].b < ord[k].b ? longint'(ord[i].b) : longint'(ord[k].b)) -
                 (ord[i].t > ord[k].t ? longint'(ord[i].t) : longint'(ord[k].t));
            if (ih <= 0) continue;
            inter = iw * ih;
            aa = area(ord[i]);
            ab = area(ord[k]);
            den = use_union ? (aa + ab - inter) : (aa < ab ? aa : ab);
            if (100 * inter > longint'(pct) * den) keep[k] = 1'b0;
          end
        end
      end
      last_pos = -1;
      foreach (keep[i]) if (keep[i]) last_pos = i;
      foreach (ord[i]) begin
        if (!keep[i]) continue;
        o = ord[i];
        o.last = (i == last_pos);
        kept_q = {kept_q, o};
      end
      frame_boxes.delete();
    endfunction

    function void check_box(det_t a);
      det_t e;
      results_seen++;
      if (kept_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected box %h %h %h %h %h %b",
                                       a.l, a.t, a.r, a.b, a.s, a.last);
        return;
      end
      e = kept_q.pop_front();
      if (a.l !== e.l || a.t !== e.t || a.r !== e.r || a.b !== e.b ||
          a.s !== e.s || a.last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: box exp %h %h %h %h %h %b got %h %h %h %h %h %b",
                   e.l, e.t, e.r, e.b, e.s, e.last, a.l, a.t, a.r, a.b, a.s, a.last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [19:0] left_i = '0, top_i = '0, right_i = '0, bottom_i = '0;
  logic [23:0] score_i = '0;
  logic        frame_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [19:0] out_left_o, out_top_o, out_right_o, out_bottom_o;
  logic [23:0] out_score_o;
  logic        out_last_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [6:0]  cfg_wdata_i = '0;

  suppression_board board = new();
  bit gaps_on = 1'b1;
  bit hold_off = 1'b0;
  int sent_boxes;

  always #5 clk_i = ~clk_i;

  greedy_box_suppression dut (.*);

  // sample accepted results at the clock edge, before the registers update
  always @(posedge clk_i) begin
    det_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.l = out_left_o; got.t = out_top_o; got.r = out_right_o;
      got.b = out_bottom_o; got.s = out_score_o; got.last = out_last_o;
      board.check_box(got);
    end
  end

  // receiver stalls in bursts, plus one long hold-off
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (gaps_on && $urandom_range(3) == 0) begin
        out_stall_i <= 1'b1;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      gbs_pkg::CFG_SUPPRESS_ENABLE:   board.en_sup = val[0];
      gbs_pkg::CFG_UNION_DENOMINATOR: board.use_union = val[0];
      default:                        board.pct = val;
    endcase
  endtask

  task automatic send_box(input det_t d);
    int n;
    if (gaps_on && $urandom_range(4) == 0) begin
      in_valid_i <= 1'b0;
      n = $urandom_range(1, 10);
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_i <= d.l; top_i <= d.t; right_i <= d.r; bottom_i <= d.b;
    score_i <= d.s; frame_end_i <= d.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_box(d);
    sent_boxes++;
  endtask

  function automatic det_t rand_box(bit last, bit tight);
    det_t d;
    int unsigned span;
    span = tight ? 400 : 1048575;
    d.l = 20'($urandom_range(span));
    d.t = 20'($urandom_range(span));
    d.r = d.l + 20'($urandom_range(1, tight ? 300 : 1048575 - d.l));
    d.b = d.t + 20'($urandom_range(1, tight ? 300 : 1048575 - d.t));
    if (!tight && d.r <= d.l) d.r = d.l + 20'd1;
    if ($urandom_range(9) == 0) begin
      d.r = 20'($urandom); d.b = 20'($urandom);
    end
    d.s = $urandom_range(3) == 0 ? 24'($urandom_range(3)) : 24'($urandom);
    d.last = last;
    return d;
  endfunction

  task automatic send_frame(input int n, input bit tight);
    for (int i = 0; i < n; i++) send_box(rand_box(i == n - 1, tight));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.kept_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  initial begin
    det_t d;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // extremes: full-range box, zero box, near-duplicates with equal score
    d = '{20'h0, 20'h0, 20'hFFFFF, 20'hFFFFF, 24'h7FFFFF, 1'b0};
    send_box(d);
    d.s = 24'h800000; send_box(d);
    d = '{20'h0, 20'h0, 20'h0, 20'h0, 24'h0, 1'b0}; send_box(d);
    d = '{20'h10, 20'h10, 20'h20, 20'h20, 24'h5, 1'b0}; send_box(d);
    d.l = 20'h11; send_box(d);
    d = '{20'h30, 20'h30, 20'h10, 20'h10, 24'h5, 1'b1}; send_box(d); // inverted box
    send_box('{20'h5, 20'h5, 20'h9, 20'h9, 24'h1, 1'b1});           // single-box frame
    drain();
    write_reg(gbs_pkg::CFG_UNION_DENOMINATOR, 7'd1);
    write_reg(gbs_pkg::CFG_OVERLAP_PERCENT, 7'd0);
    send_frame(4, 1'b1);
    drain();
    write_reg(gbs_pkg::CFG_OVERLAP_PERCENT, 7'd127);
    send_frame(4, 1'b1);
    drain();
    // buffer overflow: frame longer than the store
    write_reg(gbs_pkg::CFG_OVERLAP_PERCENT, 7'd100);
    write_reg(gbs_pkg::CFG_UNION_DENOMINATOR, 7'd0);
    send_frame(NBoxes + 3, 1'b1);
    drain();
    write_reg(gbs_pkg::CFG_SUPPRESS_ENABLE, 7'd0);
    hold_off = 1'b1;
    send_frame(6, 1'b0);
    send_frame(4, 1'b1);
    drain();
    write_reg(gbs_pkg::CFG_SUPPRESS_ENABLE, 7'd1);
    write_reg(gbs_pkg::CFG_OVERLAP_PERCENT, 7'd50);
    for (int f = 0; f < 3; f++) send_frame($urandom_range(1, 6), $urandom_range(3) != 0);
    drain();
    write_reg(gbs_pkg::CFG_UNION_DENOMINATOR, 7'd1);
    write_reg(gbs_pkg::CFG_OVERLAP_PERCENT, 7'($urandom_range(100)));
    gaps_on = 1'b0;
    for (int f = 0; f < 2; f++) send_frame($urandom_range(1, 6), 1'b1);
    drain();
    $display("Sent %0d boxes in many frames; checked %0d kept boxes across all modes.",
             sent_boxes, board.results_seen);
    if (board.mismatches == 0 && board.kept_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/gbs_pkg.sv
rtl/gbs_cell.sv
rtl/gbs_pair.sv
rtl/greedy_box_suppression.sv
rtl/gbs_checker.sv
tb/tb_greedy_box_suppression.sv
